// ----- src/mrrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared constants, types and the CRC-16 step for the Modbus RTU response
// checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // frame store geometry
    localparam int FRAME_BYTES = 256;
    localparam int MAX_WORDS   = 125;
    localparam int STORE_AW    = $clog2(FRAME_BYTES);
    localparam int POS_W       = STORE_AW + 1;
    localparam int WIDX_W      = 7;

    // request kinds on the input tuser
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // result status codes on the output tuser
    localparam logic [2:0] ST_READ_DONE  = 3'd0;
    localparam logic [2:0] ST_WRITE_DONE = 3'd1;
    localparam logic [2:0] ST_CRC_ERR    = 3'd2;
    localparam logic [2:0] ST_EXCEPTION  = 3'd3;
    localparam logic [2:0] ST_ECHO_ERR   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT    = 3'd5;
    localparam logic [2:0] ST_DATA_WORD  = 3'd6;

    // function codes
    localparam logic [7:0] FN_READ_FIRST   = 8'd1;
    localparam logic [7:0] FN_READ_LAST    = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL   = 8'd5;
    localparam logic [7:0] FN_WRITE_REG    = 8'd6;
    localparam logic [7:0] FN_WRITE_COILS  = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS   = 8'd16;
    localparam logic [7:0] EXC_BIT         = 8'h80;

    // frame lengths
    localparam logic [POS_W-1:0] EXC_LEN   = POS_W'(5);
    localparam logic [POS_W-1:0] WRITE_LEN = POS_W'(8);

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // write into the frame store
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    // one byte through the reflected Modbus CRC-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- src/modbus_rtu_response_checker_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core
// Receive side of a Modbus RTU client: checks the response to one armed
// request (CRC, exception, write echo), counts a timeout and serves data words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_        in         s_tvalid / s_tready       s_tuser kind, s_tdata request
//  m_        out        m_tvalid / m_tready       m_tuser status, m_tdata reply
//  cfg_      in         cfg_valid / cfg_ready     cfg_data timeout in ms
//
//  One request per cycle while the result is not stalled; a request is held
//  in the input register at acceptance, and its result is loaded from there
//  into the result register. Data words are read from the frame store memory
//  at acceptance into its read registers and used when the request is processed.
//  A stalled result holds the input register; the block keeps taking a
//  request whenever the input register moves on in the same cycle.
//  Synchronous active-low reset; the frame store has no clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request: [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    // request: [7:0] rx_byte, [15:8] server_address, [23:16] function_code,
    // [39:24] start_address, [55:40] quantity, [62:56] word_index, [63] zero
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // result: [2:0] status
    output logic [2:0]       m_tuser,
    // result: [7:0] reply_address, [15:8] reply_function, [23:16] detail,
    // [39:24] data_word
    output logic [39:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // timeout register write
    input  wire logic [15:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import mrrc_pkg::*;

    logic s_fire;
    logic proc_fire;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [1:0]        in_type_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        in_addr_reg;
    logic [7:0]        in_func_reg;
    logic [15:0]       in_start_reg;
    logic [15:0]       in_qty_reg;

    // request state
    logic              busy_reg, busy_next;
    logic [7:0]        want_address_reg, want_address_next;
    logic [7:0]        want_function_reg, want_function_next;
    logic [15:0]       want_start_reg, want_start_next;
    logic [15:0]       want_count_reg, want_count_next;
    logic [POS_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [15:0]       timeout_reg;
    logic [7:0]        head_reg [6];
    logic [7:0]        head_next [6];

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg;
    logic [7:0]        m_addr_reg;
    logic [7:0]        m_func_reg;
    logic [7:0]        m_detail_reg;
    logic [15:0]       m_word_reg;

    // processing
    store_wr_t         wr;
    logic [15:0]       rd_word;
    logic              emit;
    logic              go_idle;
    logic [2:0]        res_status;
    logic [7:0]        res_func;
    logic [7:0]        res_detail;
    logic [15:0]       res_word;
    logic [POS_W-1:0]  pos_inc;
    logic [15:0]       crc_new;
    logic [16:0]       el_inc;
    logic [7:0]        f [6];

    // handshakes
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_word_reg, m_detail_reg, m_func_reg, m_addr_reg};

    // frame store
    mrrc_frame_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .rd_en    (s_fire),
        .rd_index (s_tdata[62:56]),
        .rd_word  (rd_word)
    );

    // input register
    assign in_valid_next = s_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_type_reg  <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_addr_reg  <= s_tdata[15:8];
            in_func_reg  <= s_tdata[23:16];
            in_start_reg <= s_tdata[39:24];
            in_qty_reg   <= s_tdata[55:40];
        end
    end

    // request processing
    always_comb begin
        busy_next          = busy_reg;
        want_address_next  = want_address_reg;
        want_function_next = want_function_reg;
        want_start_next    = want_start_reg;
        want_count_next    = want_count_reg;
        byte_pos_next      = byte_pos_reg;
        crc_next           = crc_reg;
        elapsed_next       = elapsed_reg;
        for (int k = 0; k < 6; k++) begin
            head_next[k] = head_reg[k];
        end
        wr         = '0;
        emit       = 1'b0;
        go_idle    = 1'b0;
        res_status = ST_DATA_WORD;
        res_func   = want_function_reg;
        res_detail = 8'd0;
        res_word   = 16'd0;
        pos_inc    = byte_pos_reg + POS_W'(1);
        crc_new    = crc_byte(crc_reg, in_byte_reg);
        el_inc     = {1'b0, elapsed_reg} + 17'd1;

        // header bytes as they stand after this byte is stored
        for (int k = 0; k < 6; k++) begin
            f[k] = (byte_pos_reg == POS_W'(k)) ? in_byte_reg : head_reg[k];
        end

        if (proc_fire) begin
            unique case (in_type_reg)
                REQ_BYTE: begin
                    if (busy_reg && (byte_pos_reg < POS_W'(FRAME_BYTES))) begin
                        wr.en         = 1'b1;
                        wr.addr       = byte_pos_reg[STORE_AW-1:0];
                        wr.data       = in_byte_reg;
                        byte_pos_next = pos_inc;
                        crc_next      = crc_new;
                        for (int k = 0; k < 6; k++) begin
                            head_next[k] = f[k];
                        end
                        if ((pos_inc >= EXC_LEN) && (f[0] == want_address_reg)) begin
                            if ((f[1] & EXC_BIT) != 8'd0) begin
                                // exception response is five bytes long
                                if (pos_inc == EXC_LEN) begin
                                    go_idle = 1'b1;
                                    emit    = 1'b1;
                                    if (crc_new != 16'd0) begin
                                        res_status = ST_CRC_ERR;
                                    end else begin
                                        res_status = ST_EXCEPTION;
                                        res_func   = f[1] & ~EXC_BIT;
                                        res_detail = f[2];
                                    end
                                end
                            end else if (pos_inc > EXC_LEN) begin
                                case (f[1]) inside
                                    [FN_READ_FIRST:FN_READ_LAST]: begin
                                        // byte count plus address, function, count, crc
                                        if (pos_inc == ({1'b0, f[2]} + EXC_LEN)) begin
                                            go_idle = 1'b1;
                                            emit    = 1'b1;
                                            if (crc_new != 16'd0) begin
                                                res_status = ST_CRC_ERR;
                                            end else begin
                                                res_status = ST_READ_DONE;
                                                res_func   = f[1];
                                                res_detail = f[2];
                                            end
                                        end
                                    end
                                    FN_WRITE_COIL, FN_WRITE_REG,
                                    FN_WRITE_COILS, FN_WRITE_REGS: begin
                                        if (pos_inc == WRITE_LEN) begin
                                            go_idle = 1'b1;
                                            emit    = 1'b1;
                                            if (crc_new != 16'd0) begin
                                                res_status = ST_CRC_ERR;
                                            end else begin
                                                res_func = f[1];
                                                if (({f[2], f[3]} == want_start_reg) &&
                                                    ({f[4], f[5]} == want_count_reg)) begin
                                                    res_status = ST_WRITE_DONE;
                                                end else begin
                                                    res_status = ST_ECHO_ERR;
                                                end
                                            end
                                        end
                                    end
                                    default: begin
                                        // unknown function drops the request
                                        go_idle = 1'b1;
                                    end
                                endcase
                            end
                        end
                    end
                end
                REQ_BEGIN: begin
                    if (!busy_reg && (in_addr_reg != 8'd0)) begin
                        want_address_next  = in_addr_reg;
                        want_function_next = in_func_reg;
                        want_start_next    = in_start_reg;
                        want_count_next    = in_qty_reg;
                        byte_pos_next      = '0;
                        crc_next           = CRC_INIT;
                        elapsed_next       = 16'd0;
                        busy_next          = 1'b1;
                    end
                end
                REQ_TICK: begin
                    if (busy_reg) begin
                        if (el_inc > {1'b0, timeout_reg}) begin
                            go_idle    = 1'b1;
                            emit       = 1'b1;
                            res_status = ST_TIMEOUT;
                        end else begin
                            elapsed_next = el_inc[15:0];
                        end
                    end
                end
                REQ_READ: begin
                    emit       = 1'b1;
                    res_status = ST_DATA_WORD;
                    res_word   = rd_word;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        // return to idle
        if (go_idle) begin
            busy_next     = 1'b0;
            byte_pos_next = '0;
            crc_next      = CRC_INIT;
            elapsed_next  = 16'd0;
        end
    end

    // request state and timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            want_address_reg  <= 8'd0;
            want_function_reg <= 8'd0;
            want_start_reg    <= 16'd0;
            want_count_reg    <= 16'd0;
            byte_pos_reg      <= '0;
            crc_reg           <= CRC_INIT;
            elapsed_reg       <= 16'd0;
            timeout_reg       <= TIMEOUT_RESET;
        end else begin
            busy_reg          <= busy_next;
            want_address_reg  <= want_address_next;
            want_function_reg <= want_function_next;
            want_start_reg    <= want_start_next;
            want_count_reg    <= want_count_next;
            byte_pos_reg      <= byte_pos_next;
            crc_reg           <= crc_next;
            elapsed_reg       <= elapsed_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // copy of the first six frame bytes
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 6; k++) begin
            head_reg[k] <= head_next[k];
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc_fire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            m_status_reg <= res_status;
            m_addr_reg   <= want_address_reg;
            m_func_reg   <= res_func;
            m_detail_reg <= res_detail;
            m_word_reg   <= res_word;
        end
    end

endmodule
`default_nettype wire

// ----- src/mrrc_frame_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrc_frame_store
// Response byte memory: one write port, two registered read ports that fetch
// the big-endian data word at a given word index, with write bypass.
// ----------------------------------------------------------------------------
module mrrc_frame_store (
    input  wire logic                       aclk,
    input  wire mrrc_pkg::store_wr_t        wr,
    input  wire logic                       rd_en,
    input  wire logic [mrrc_pkg::WIDX_W-1:0] rd_index,
    output logic [15:0]                     rd_word
);
    import mrrc_pkg::*;

    logic [7:0]          mem [FRAME_BYTES];
    logic [STORE_AW-1:0] addr_hi;
    logic [STORE_AW-1:0] addr_lo;
    logic                in_range;

    logic [7:0] hi_reg;
    logic [7:0] lo_reg;
    logic       hi_fwd_reg;
    logic       lo_fwd_reg;
    logic [7:0] fwd_data_reg;
    logic       range_reg;

    // data word i lives at bytes 3+2i (high) and 4+2i (low)
    assign addr_hi  = STORE_AW'({1'b0, rd_index, 1'b0} + 9'd3);
    assign addr_lo  = STORE_AW'({1'b0, rd_index, 1'b0} + 9'd4);
    assign in_range = ({25'd0, rd_index} < MAX_WORDS);

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read ports, a write in the same cycle is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hi_reg       <= mem[addr_hi];
            lo_reg       <= mem[addr_lo];
            hi_fwd_reg   <= wr.en && (wr.addr == addr_hi);
            lo_fwd_reg   <= wr.en && (wr.addr == addr_lo);
            fwd_data_reg <= wr.data;
            range_reg    <= in_range;
        end
    end

    always_comb begin
        rd_word = 16'd0;
        if (range_reg) begin
            rd_word[15:8] = hi_fwd_reg ? fwd_data_reg : hi_reg;
            rd_word[7:0]  = lo_fwd_reg ? fwd_data_reg : lo_reg;
        end
    end

endmodule
`default_nettype wire

// ----- src/mrrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrc_checker
// Port-level checks on the response checker results, bound to the top level.
// ----------------------------------------------------------------------------
module mrrc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [2:0]  m_tuser,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import mrrc_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no result straight out of reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result right after reset");

    // data word only carried by data word results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DATA_WORD) |-> (m_tdata[39:24] == 16'd0))
        else $error("data word on a status result");

    // detail only for read done and exception
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_READ_DONE) && (m_tuser != ST_EXCEPTION)
        |-> (m_tdata[23:16] == 8'd0))
        else $error("detail set on wrong status");

endmodule

bind modbus_rtu_response_checker_core mrrc_checker u_mrrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU response checker. Requests (bytes,
// begins, millisecond ticks, word reads) go in over the input stream with
// random gaps. A shadow of the checker state predicts every reply, and each
// reply taken from the output stream is compared field by field in order.
// Short directed cases come first, then random response frames with good and
// broken CRCs, write echoes, exceptions and noise, under several timeouts.
// ----------------------------------------------------------------------------
module tb;
    import mrrc_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;

    // one request, as carried on the input stream
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx;
        logic [7:0]  srv;
        logic [7:0]  fcode;
        logic [15:0] start;
        logic [15:0] qty;
        logic [6:0]  widx;
    } request_t;

    // one reply, as carried on the output stream
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  addr;
        logic [7:0]  fcode;
        logic [7:0]  detail;
        logic [15:0] word;
    } reply_t;

    logic        aclk;
    logic        aresetn;
    logic [1:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    // shadow of the checker state
    logic        sh_busy;
    logic [7:0]  sh_addr;
    logic [7:0]  sh_fcode;
    logic [15:0] sh_start;
    logic [15:0] sh_qty;
    int          sh_pos;
    logic [15:0] sh_crc;
    logic [7:0]  sh_store [FRAME_BYTES];
    logic [15:0] sh_elapsed;
    logic [15:0] sh_timeout_ms;
    int          store_fill;

    reply_t      pending_replies[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches;
    int          acted_count;
    bit          src_steady;
    bit          sink_steady;

    modbus_rtu_response_checker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run-away guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // reflected modbus crc, one bit of the byte at a time
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0]  d);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic bit is_read_code(input logic [7:0] f);
        return f >= FN_READ_FIRST && f <= FN_READ_LAST;
    endfunction

    function automatic bit is_write_code(input logic [7:0] f);
        return f == FN_WRITE_COIL || f == FN_WRITE_REG ||
               f == FN_WRITE_COILS || f == FN_WRITE_REGS;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic reply_t reply_of(input logic [2:0] st, input logic [7:0] f,
                                        input logic [7:0] det, input logic [15:0] w);
        reply_t rep;
        rep.status = st;
        rep.addr   = sh_addr;
        rep.fcode  = f;
        rep.detail = det;
        rep.word   = w;
        return rep;
    endfunction

    task automatic clear_frame();
        sh_busy    = 1'b0;
        sh_pos     = 0;
        sh_crc     = CRC_INIT;
        sh_elapsed = '0;
    endtask

    // advance the shadow by one accepted request and queue its reply
    task automatic predict_reply(input request_t r);
        reply_t     rep;
        bit         has;
        logic [7:0] fb;
        int         idx;
        has = 1'b0;
        rep = '0;
        case (r.kind)
            REQ_BYTE: begin
                if (sh_busy && sh_pos < FRAME_BYTES) begin
                    acted_count++;
                    sh_store[sh_pos] = r.rx;
                    sh_pos++;
                    if (sh_pos > store_fill) store_fill = sh_pos;
                    sh_crc = modbus_crc_step(sh_crc, r.rx);
                    fb = sh_store[1];
                    if (sh_pos >= int'(EXC_LEN) && sh_store[0] == sh_addr) begin
                        if ((fb & EXC_BIT) != 0) begin
                            // exception reply is always five bytes
                            if (sh_pos == int'(EXC_LEN)) begin
                                has = 1'b1;
                                if (sh_crc != 0)
                                    rep = reply_of(ST_CRC_ERR, sh_fcode, '0, '0);
                                else
                                    rep = reply_of(ST_EXCEPTION, fb & ~EXC_BIT,
                                                   sh_store[2], '0);
                                clear_frame();
                            end
                        end else if (sh_pos > int'(EXC_LEN)) begin
                            if (is_read_code(fb)) begin
                                if (sh_pos == int'(sh_store[2]) + int'(EXC_LEN)) begin
                                    has = 1'b1;
                                    if (sh_crc != 0)
                                        rep = reply_of(ST_CRC_ERR, sh_fcode, '0, '0);
                                    else
                                        rep = reply_of(ST_READ_DONE, fb, sh_store[2], '0);
                                    clear_frame();
                                end
                            end else if (is_write_code(fb)) begin
                                if (sh_pos == int'(WRITE_LEN)) begin
                                    has = 1'b1;
                                    if (sh_crc != 0)
                                        rep = reply_of(ST_CRC_ERR, sh_fcode, '0, '0);
                                    else if ({sh_store[2], sh_store[3]} == sh_start &&
                                             {sh_store[4], sh_store[5]} == sh_qty)
                                        rep = reply_of(ST_WRITE_DONE, fb, '0, '0);
                                    else
                                        rep = reply_of(ST_ECHO_ERR, fb, '0, '0);
                                    clear_frame();
                                end
                            end else begin
                                // unknown function drops the request quietly
                                clear_frame();
                            end
                        end
                    end
                end
            end
            REQ_BEGIN: begin
                if (!sh_busy && r.srv != 0) begin
                    acted_count++;
                    sh_addr  = r.srv;
                    sh_fcode = r.fcode;
                    sh_start = r.start;
                    sh_qty   = r.qty;
                    clear_frame();
                    sh_busy  = 1'b1;
                end
            end
            REQ_TICK: begin
                if (sh_busy) begin
                    acted_count++;
                    if (int'(sh_elapsed) + 1 > int'(sh_timeout_ms)) begin
                        has = 1'b1;
                        rep = reply_of(ST_TIMEOUT, sh_fcode, '0, '0);
                        clear_frame();
                    end else begin
                        sh_elapsed = sh_elapsed + 16'd1;
                    end
                end
            end
            REQ_READ: begin
                acted_count++;
                has = 1'b1;
                idx = int'(r.widx);
                if (idx < MAX_WORDS)
                    rep = reply_of(ST_DATA_WORD, sh_fcode, '0,
                                   {sh_store[3 + 2 * idx], sh_store[4 + 2 * idx]});
                else
                    rep = reply_of(ST_DATA_WORD, sh_fcode, '0, '0);
            end
            default: ;
        endcase
        if (has) pending_replies.push_back(rep);
    endtask

    // one request onto the input stream, held until taken
    task automatic push_request(input request_t r);
        int gap;
        gap = pick_gap(src_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = r.kind;
        s_tdata  = {1'b0, r.widx, r.qty, r.start, r.fcode, r.srv, r.rx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_reply(r);
    endtask

    function automatic request_t random_request(input logic [1:0] kind);
        request_t r;
        r.kind  = kind;
        r.rx    = 8'($urandom_range(0, 255));
        r.srv   = 8'($urandom_range(0, 255));
        r.fcode = 8'($urandom_range(0, 255));
        r.start = 16'($urandom_range(0, 65535));
        r.qty   = 16'($urandom_range(0, 65535));
        r.widx  = 7'($urandom_range(0, 127));
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        request_t r;
        r = random_request(REQ_BYTE);
        r.rx = b;
        push_request(r);
    endtask

    task automatic send_begin(input logic [7:0] a, input logic [7:0] f,
                              input logic [15:0] s, input logic [15:0] q);
        request_t r;
        r = random_request(REQ_BEGIN);
        r.srv   = a;
        r.fcode = f;
        r.start = s;
        r.qty   = q;
        push_request(r);
    endtask

    task automatic send_tick();
        push_request(random_request(REQ_TICK));
    endtask

    task automatic send_read(input logic [6:0] i);
        request_t r;
        r = random_request(REQ_READ);
        r.widx = i;
        push_request(r);
    endtask

    // only words whose bytes have been stored, or out-of-range indexes
    task automatic send_random_read();
        int top;
        if (store_fill < 5 || $urandom_range(0, 7) == 0) begin
            send_read(7'($urandom_range(MAX_WORDS, 127)));
        end else begin
            top = (store_fill - 5) / 2;
            if (top > MAX_WORDS - 1) top = MAX_WORDS - 1;
            send_read(7'($urandom_range(0, top)));
        end
    endtask

    // frame_bytes onto the line, optionally closed with a good or broken crc
    task automatic send_frame(input bit add_crc, input bit bad_crc);
        logic [15:0] crc_acc;
        crc_acc = CRC_INIT;
        if (add_crc) begin
            for (int k = 0; k < frame_bytes.size(); k++)
                crc_acc = modbus_crc_step(crc_acc, frame_bytes[k]);
            if (bad_crc) crc_acc = crc_acc ^ (16'd1 << $urandom_range(0, 15));
            frame_bytes.push_back(crc_acc[7:0]);
            frame_bytes.push_back(crc_acc[15:8]);
        end
        for (int k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k]);
    endtask

    // hold off the sender until every reply is in and the pipe is empty
    task automatic wait_for_results();
        int n;
        n = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] ms);
        wait_for_results();
        @(negedge aclk);
        cfg_data  = ms;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sh_timeout_ms = ms;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got_v,
                                 input logic [15:0] want_v);
        $display("%0t: %s: got %h, expected %h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // reply checker
    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.addr   = m_tdata[7:0];
            got.fcode  = m_tdata[15:8];
            got.detail = m_tdata[23:16];
            got.word   = m_tdata[39:24];
            if (pending_replies.size() == 0) begin
                flag_mismatch("unexpected reply, status", 16'(got.status), 16'hFFFF);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 16'(got.status), 16'(want.status));
                if (got.addr !== want.addr)
                    flag_mismatch("reply address", 16'(got.addr), 16'(want.addr));
                if (got.fcode !== want.fcode)
                    flag_mismatch("reply function", 16'(got.fcode), 16'(want.fcode));
                if (got.detail !== want.detail)
                    flag_mismatch("detail", 16'(got.detail), 16'(want.detail));
                if (got.word !== want.word)
                    flag_mismatch("data word", got.word, want.word);
            end
        end
    end

    // reply sink with random stalls
    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                hold = pick_gap(sink_steady);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reads, a byte and a tick with no request armed
    task automatic test_idle_requests();
        send_read(7'd127);
        send_read(7'(MAX_WORDS));
        send_byte(8'hFF);
        send_tick();
    endtask

    // zero address refused, then a five byte exception reply
    task automatic test_exception_reply();
        send_begin(8'd0, FN_WRITE_REG, 16'h1234, 16'h5678);
        send_begin(8'd1, FN_WRITE_REG, 16'h0000, 16'h0000);
        frame_bytes = {8'd1, EXC_BIT | FN_WRITE_REG, EXC_ILLEGAL_ADDR};
        send_frame(1'b1, 1'b0);
    endtask

    // write echo at the top of every field
    task automatic test_write_echo();
        send_begin(8'hFF, FN_WRITE_REGS, 16'hFFFF, 16'hFFFF);
        frame_bytes = {8'hFF, FN_WRITE_REGS, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b1, 1'b0);
    endtask

    // a short read reply and its data word
    task automatic test_read_reply();
        send_begin(8'h80, FN_READ_LAST, 16'h0000, 16'h0001);
        frame_bytes = {8'h80, FN_READ_LAST, 8'd2, 8'hAB, 8'hCD};
        send_frame(1'b1, 1'b0);
        send_read(7'd0);
    endtask

    // shortest and longest timeout settings
    task automatic test_timeout_extremes();
        write_timeout(16'd1);
        send_begin(8'h2A, FN_READ_FIRST, 16'h0010, 16'h0004);
        send_tick();
        send_tick();
        write_timeout(16'hFFFF);
        send_begin(8'h2A, FN_WRITE_COIL, 16'h00AC, 16'hFF00);
        repeat (3) send_tick();
        frame_bytes = {8'h2A, FN_WRITE_COIL, 8'h00, 8'hAC, 8'hFF, 8'h00};
        send_frame(1'b1, 1'b0);
        send_read(7'd0);
    endtask

    // overlong read reply: bytes past a full store are dropped, then timeout
    task automatic test_store_full();
        write_timeout(16'd3);
        send_begin(8'h5A, FN_READ_LAST, 16'h0000, 16'h007D);
        frame_bytes = {8'h5A, FN_READ_LAST, 8'd253};
        repeat (FRAME_BYTES + 2 - 3) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0, 1'b0);
        while (sh_busy) send_tick();
        repeat (24) send_random_read();
        send_read(7'(MAX_WORDS - 1));
        send_read(7'd126);
    endtask

    // one armed request and a random response to it
    task automatic random_exchange();
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  rf;
        logic [15:0] s;
        logic [15:0] q;
        logic [31:0] echo;
        int          pick;
        int          n;
        int          ticks;
        bit          bad;
        if ($urandom_range(0, 11) == 0) src_steady = !src_steady;
        if ($urandom_range(0, 11) == 0) sink_steady = !sink_steady;
        pick = $urandom_range(0, 9);
        a = (pick == 0) ? 8'd1 : (pick == 1) ? 8'hFF : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f = 8'($urandom_range(FN_READ_FIRST, FN_READ_LAST));
            4: f = FN_WRITE_COIL;
            5: f = FN_WRITE_REG;
            6: f = FN_WRITE_COILS;
            7: f = FN_WRITE_REGS;
            default: f = 8'($urandom_range(0, 255));
        endcase
        s = 16'($urandom_range(0, 65535));
        q = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 19) == 0) send_begin(8'd0, f, s, q);
        send_begin(a, f, s, q);
        if ($urandom_range(0, 2) == 0 && sh_timeout_ms > 1) begin
            ticks = $urandom_range(0, (sh_timeout_ms > 5) ? 4 : int'(sh_timeout_ms) - 1);
            repeat (ticks) send_tick();
        end
        bad = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        frame_bytes.delete();
        if (pick < 35) begin
            // read reply, mostly short, now and then up to a full store
            rf = is_read_code(f) ? f : 8'($urandom_range(FN_READ_FIRST, FN_READ_LAST));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, FRAME_BYTES - 5)
                                             : $urandom_range(1, 12);
            frame_bytes = {a, rf, 8'(n)};
            repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame(1'b1, bad);
        end else if (pick < 55) begin
            // write echo, sometimes with one bit off
            case ($urandom_range(0, 3))
                0: rf = FN_WRITE_COIL;
                1: rf = FN_WRITE_REG;
                2: rf = FN_WRITE_COILS;
                default: rf = FN_WRITE_REGS;
            endcase
            if (is_write_code(f)) rf = f;
            echo = {s, q};
            if ($urandom_range(0, 3) == 0) echo = echo ^ (32'd1 << $urandom_range(0, 31));
            frame_bytes = {a, rf, echo[31:24], echo[23:16], echo[15:8], echo[7:0]};
            send_frame(1'b1, bad);
        end else if (pick < 70) begin
            rf = ($urandom_range(0, 1) == 0) ? (f | EXC_BIT)
                                             : 8'($urandom_range(EXC_BIT, 255));
            frame_bytes = {a, rf, 8'($urandom_range(0, 255))};
            send_frame(1'b1, bad);
        end else if (pick < 78) begin
            // unknown function code without the exception bit
            do rf = 8'($urandom_range(0, EXC_BIT - 1));
            while (is_read_code(rf) || is_write_code(rf));
            frame_bytes = {a, rf};
            repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame(1'b1, bad);
        end else if (pick < 88) begin
            // another server answering
            frame_bytes = {a ^ 8'($urandom_range(1, 255))};
            repeat ($urandom_range(3, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame(1'b0, 1'b0);
        end else begin
            repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame(1'b0, 1'b0);
        end
        // a second begin while still armed is ignored
        if (sh_busy && $urandom_range(0, 1) == 0)
            send_begin(8'($urandom_range(1, 255)), f, q, s);
        repeat ($urandom_range(0, 3)) send_random_read();
        while (sh_busy && sh_timeout_ms <= 64) send_tick();
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) send_tick();
    endtask

    task automatic test_random_traffic(input logic [15:0] ms, input int n_items);
        int  target;
        bit  paused;
        write_timeout(ms);
        target = acted_count + n_items;
        paused = 1'b0;
        while (acted_count < target) begin
            random_exchange();
            if (!paused && acted_count >= target - n_items / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    // ----------------------------------------------------------------- main
    initial begin
        aresetn   = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_data  = '0;
        cfg_valid = 1'b0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        mismatches  = 0;
        acted_count = 0;
        store_fill  = 0;
        sh_addr  = '0;
        sh_fcode = '0;
        sh_start = '0;
        sh_qty   = '0;
        sh_timeout_ms = TIMEOUT_RESET;
        for (int k = 0; k < FRAME_BYTES; k++) sh_store[k] = '0;
        clear_frame();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_requests();
        test_exception_reply();
        test_write_echo();
        test_read_reply();
        test_timeout_extremes();
        test_store_full();
        test_random_traffic(16'd2, 280);
        test_random_traffic(16'd7, 280);
        test_random_traffic(16'd40, 280);
        test_random_traffic(16'd1, 280);
        test_random_traffic(16'd12, 280);

        wait_for_results();
        while (pending_replies.size() != 0) begin
            flag_mismatch("reply never arrived, status",
                          16'hFFFF, 16'(pending_replies[0].status));
            void'(pending_replies.pop_front());
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- modbus_rtu_response_checker_core.f -----
src/mrrc_pkg.sv
src/mrrc_frame_store.sv
src/modbus_rtu_response_checker_core.sv
src/mrrc_checker.sv
sim/tb.sv
